@@ rtl/core/lfsc_pkg.sv @@
package lfsc_pkg;

  localparam int LABEL_W         = 12;
  localparam int NEXT_W          = LABEL_W + 1;
  localparam int LABEL_SLOTS_DEF = 4096;
  localparam int EPOCH_W         = 6;

  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [NEXT_W-1:0]  next_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  localparam label_t LABEL_MAX = '1;
  localparam epoch_t EPOCH_MAX = '1;
  localparam epoch_t EPOCH_ONE = epoch_t'(1);

  // sweep engine status seen by the relabel stage
  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

  // epoch 0 is reserved for swept (invalid) entries
  function automatic epoch_t epoch_inc(input epoch_t e);
    epoch_t r;
    if (e == EPOCH_MAX) begin
      r = EPOCH_ONE;
    end else begin
      r = e + EPOCH_ONE;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/lfsc_ifs.sv @@
interface lfsc_pix_if
  import lfsc_pkg::*;
  ();
  logic   valid;
  logic   ready;
  label_t old_label;
  logic   start_of_video;

  modport source (output valid, output old_label, output start_of_video, input ready);
  modport sink   (input valid, input old_label, input start_of_video, output ready);
endinterface

interface lfsc_lab_if
  import lfsc_pkg::*;
  ();
  logic   valid;
  logic   ready;
  label_t compact_label;
  logic   first_seen;
  logic   overflow;

  modport source (output valid, output compact_label, output first_seen, output overflow,
                  input ready);
  modport sink   (input valid, input compact_label, input first_seen, input overflow,
                  output ready);
endinterface

@@ rtl/core/label_first_seen_compaction.sv @@
// Label first-seen compaction: renumbers a pixel stream of segment labels so
// labels count up in order of first sighting, starting from cfg start label.
// Channels: pix_i takes {old_label, start_of_video}, lab_o gives
// {compact_label, first_seen, overflow}; valid/ready, taken when both high.
// cfg_we_i/cfg_wdata_i write the start label; write only while idle.
// A taken item is held in the input stage register, then its result in the
// result register. Throughput: one item per cycle while lab_o is not stalled
// and no sweep runs, limited by the one read and one write port of the label
// table; the item in the input stage forwards its write to the next item.
// Valid bits are epoch tags stored with each table entry. Reset starts a sweep
// that writes tag 0 to every entry; pix_i.ready stays low until it ends. Once
// every 63 videos the epoch wraps and the start-of-video item waits in the
// input stage while the table is swept again.
// When lab_o is stalled the result register holds and pix_i takes one more
// item into the input stage, then ready drops until the result is taken.
module label_first_seen_compaction
  import lfsc_pkg::*;
#(
  parameter int LABEL_SLOTS = LABEL_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  label_t     cfg_wdata_i,
  lfsc_pix_if.sink   pix_i,
  lfsc_lab_if.source lab_o
);

  localparam int AW = $clog2(LABEL_SLOTS);

  sweep_stat_t   stat;
  logic          sweep_req;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  epoch_t        rd_tag;
  label_t        rd_label;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  epoch_t        wr_tag;
  label_t        wr_label;

  lfsc_relabel #(
    .LABEL_SLOTS (LABEL_SLOTS),
    .AW          (AW)
  ) u_relabel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_i),
    .lab_o       (lab_o),
    .stat_i      (stat),
    .sweep_req_o (sweep_req),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_tag_i    (rd_tag),
    .rd_label_i  (rd_label),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_tag_o    (wr_tag),
    .wr_label_o  (wr_label)
  );

  lfsc_table #(
    .LABEL_SLOTS (LABEL_SLOTS),
    .AW          (AW)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sweep_req_i (sweep_req),
    .stat_o      (stat),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_tag_o    (rd_tag),
    .rd_label_o  (rd_label),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_tag_i    (wr_tag),
    .wr_label_i  (wr_label)
  );

endmodule

@@ rtl/core/lfsc_table.sv @@
module lfsc_table
  import lfsc_pkg::*;
#(
  parameter int LABEL_SLOTS = LABEL_SLOTS_DEF,
  parameter int AW          = $clog2(LABEL_SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          sweep_req_i,
  output sweep_stat_t   stat_o,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output epoch_t        rd_tag_o,
  output label_t        rd_label_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  epoch_t        wr_tag_i,
  input  label_t        wr_label_i
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(LABEL_SLOTS - 1);

  logic [EPOCH_W+LABEL_W-1:0] mem_q [LABEL_SLOTS];
  logic [EPOCH_W+LABEL_W-1:0] rd_q;
  logic                       sweeping_q;
  logic                       done_q;
  logic [AW-1:0]              swp_addr_q;

  // sweep writes tag 0 into every entry; runs out of reset and on request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweeping_q <= 1'b1;
      done_q     <= 1'b0;
      swp_addr_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (sweeping_q) begin
        if (swp_addr_q == LAST_ADDR) begin
          sweeping_q <= 1'b0;
          done_q     <= 1'b1;
        end else begin
          swp_addr_q <= swp_addr_q + AW'(1);
        end
      end else if (sweep_req_i && !done_q) begin
        sweeping_q <= 1'b1;
        swp_addr_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweeping_q) begin
      mem_q[swp_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_tag_i, wr_label_i};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_tag_o    = rd_q[EPOCH_W+LABEL_W-1:LABEL_W];
  assign rd_label_o  = rd_q[LABEL_W-1:0];
  assign stat_o.busy = sweeping_q;
  assign stat_o.done = done_q;

endmodule

@@ rtl/core/lfsc_relabel.sv @@
module lfsc_relabel
  import lfsc_pkg::*;
#(
  parameter int LABEL_SLOTS = LABEL_SLOTS_DEF,
  parameter int AW          = $clog2(LABEL_SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  label_t        cfg_wdata_i,
  lfsc_pix_if.sink      pix_i,
  lfsc_lab_if.source    lab_o,
  input  sweep_stat_t   stat_i,
  output logic          sweep_req_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  epoch_t        rd_tag_i,
  input  label_t        rd_label_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output epoch_t        wr_tag_o,
  output label_t        wr_label_o
);

  logic          s1_valid_q, s1_valid_d;
  label_t        s1_label_q;
  logic          s1_sov_q;
  epoch_t        epoch_q;
  next_t         next_q, next_d;
  label_t        start_q;
  logic          swept_q, swept_d;
  logic          fwd_en_q;
  logic [AW-1:0] fwd_addr_q;
  label_t        fwd_label_q;
  logic          out_valid_q, out_valid_d;
  label_t        out_label_q, out_label_d;
  logic          out_first_q, out_first_d;
  logic          out_ovf_q, out_ovf_d;

  logic          in_accept;
  logic          in_range;
  logic [AW-1:0] s1_addr;
  logic          wrap_wait;
  logic          s1_adv;
  logic          fwd_hit;
  logic          hit;
  label_t        hit_label;
  epoch_t        cur_epoch;
  next_t         base_next;
  logic          do_write;

  assign in_range  = 32'(s1_label_q) < 32'(LABEL_SLOTS);
  assign s1_addr   = AW'(s1_label_q);

  // the epoch is about to wrap: old tags must be swept before this item moves on
  assign wrap_wait = s1_valid_q && s1_sov_q && (epoch_q == EPOCH_MAX) && !swept_q;
  assign s1_adv    = s1_valid_q && (!out_valid_q || lab_o.ready) && !stat_i.busy && !wrap_wait;

  assign pix_i.ready = !stat_i.busy && (!s1_valid_q || s1_adv);
  assign in_accept   = pix_i.valid && pix_i.ready;
  assign sweep_req_o = wrap_wait && !stat_i.busy;

  assign rd_en_o   = in_accept;
  assign rd_addr_o = AW'(pix_i.old_label);

  // the previous item's write lands on the same edge as this item's read
  assign fwd_hit   = fwd_en_q && (fwd_addr_q == s1_addr);
  assign hit       = !s1_sov_q && (fwd_hit || (rd_tag_i == epoch_q));
  assign hit_label = fwd_hit ? fwd_label_q : rd_label_i;
  assign cur_epoch = s1_sov_q ? epoch_inc(epoch_q) : epoch_q;
  assign base_next = s1_sov_q ? {1'b0, start_q} : next_q;

  always_comb begin
    next_d      = base_next;
    do_write    = 1'b0;
    out_label_d = LABEL_MAX;
    out_first_d = 1'b0;
    out_ovf_d   = 1'b0;
    if (!in_range) begin
      out_ovf_d = 1'b1;
    end else if (hit) begin
      out_label_d = hit_label;
    end else begin
      out_first_d = 1'b1;
      do_write    = 1'b1;
      if (base_next[NEXT_W-1]) begin
        out_ovf_d = 1'b1;
      end else begin
        out_label_d = base_next[LABEL_W-1:0];
        next_d      = base_next + next_t'(1);
      end
    end
  end

  assign wr_en_o    = s1_adv && do_write;
  assign wr_addr_o  = s1_addr;
  assign wr_tag_o   = cur_epoch;
  assign wr_label_o = out_label_d;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_comb begin
    swept_d = swept_q;
    if (s1_adv || !s1_valid_q) begin
      swept_d = 1'b0;
    end else if (stat_i.done) begin
      swept_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (lab_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      epoch_q     <= EPOCH_ONE;
      next_q      <= '0;
      start_q     <= '0;
      swept_q     <= 1'b0;
      fwd_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      swept_q     <= swept_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      if (s1_adv) begin
        epoch_q  <= cur_epoch;
        next_q   <= next_d;
        fwd_en_q <= do_write;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_label_q <= pix_i.old_label;
      s1_sov_q   <= pix_i.start_of_video;
    end
    if (s1_adv) begin
      fwd_addr_q  <= s1_addr;
      fwd_label_q <= out_label_d;
      out_label_q <= out_label_d;
      out_first_q <= out_first_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign lab_o.valid         = out_valid_q;
  assign lab_o.compact_label = out_label_q;
  assign lab_o.first_seen    = out_first_q;
  assign lab_o.overflow      = out_ovf_q;

endmodule

@@ rtl/core/lfsc_checker.sv @@
module lfsc_checker
  import lfsc_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_ready_i,
  input logic   out_valid_i,
  input logic   out_ready_i,
  input label_t compact_label_i,
  input logic   first_seen_i,
  input logic   overflow_i
);

  // a stalled result keeps its fields
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(compact_label_i)
      && $stable(first_seen_i) && $stable(overflow_i))
    else $error("lab_o changed while stalled");

  // every overflow result carries the saturated label
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflow_i |-> compact_label_i == LABEL_MAX)
    else $error("overflow without saturated label");

  // the table sweep after reset blocks input
  a_reset_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_i)
    else $error("input ready during reset sweep");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind label_first_seen_compaction lfsc_checker u_lfsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (pix_i.ready),
  .out_valid_i     (lab_o.valid),
  .out_ready_i     (lab_o.ready),
  .compact_label_i (lab_o.compact_label),
  .first_seen_i    (lab_o.first_seen),
  .overflow_i      (lab_o.overflow)
);
